// File: hdl/ets_pkg.sv
// Shared types and constants of the expanding trailing stop.
`default_nettype none

package ets_pkg;

    // Fixed widths of the channel payloads.
    localparam int PRICE_PORT_W = 32;
    localparam int REL_W        = 16;
    localparam int HOLD_W       = 16;
    localparam int TICK_W       = 17;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;

    // Input command codes.
    localparam logic CMD_OPEN = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Position direction codes.
    localparam logic DIR_LONG  = 1'b0;
    localparam logic DIR_SHORT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ABSOLUTE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_RELATIVE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT    = 4'd3;

    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = 16'd10000;
    localparam logic [TICK_W-1:0] TICK_MAX         = 17'h1FFFF;

    // Configuration register set as seen by the datapath.
    typedef struct packed {
        logic                    direction;
        logic [PRICE_PORT_W-1:0] stop_absolute;
        logic [REL_W-1:0]        stop_relative;
        logic [HOLD_W-1:0]       hold_limit;
    } t_ets_cfg;

endpackage

`default_nettype wire

// File: hdl/ets_ifs.sv
// Valid/ready channel interfaces for the input, result and configuration words.
`default_nettype none

interface ets_in_if
    import ets_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [PRICE_PORT_W-1:0] ask;
    logic [PRICE_PORT_W-1:0] bid;

    modport source (output valid, output command, output ask, output bid, input ready);
    modport sink   (input valid, input command, input ask, input bid, output ready);
endinterface

interface ets_out_if
    import ets_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    close;
    logic                    timed_out;
    logic [PRICE_PORT_W-1:0] stop_distance;

    modport source (output valid, output close, output timed_out, output stop_distance,
                    input ready);
    modport sink   (input valid, input close, input timed_out, input stop_distance,
                    output ready);
endinterface

interface ets_cfg_if
    import ets_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ets_stop_calc.sv
// Stop distance arithmetic: saturated absolute stop and expanded relative stop.
`default_nettype none

module ets_stop_calc
    import ets_pkg::*;
#(
    parameter int PRICE_BITS    = 32,
    parameter int REL_FRAC_BITS = 12
) (
    input  var t_ets_cfg              i_cfg,
    input  var logic [PRICE_BITS-1:0] i_price,
    input  var logic [PRICE_BITS-1:0] i_entry,
    output var logic [PRICE_BITS-1:0] o_abs_stop,
    output var logic [PRICE_BITS-1:0] o_expanded_stop
);

    localparam int PROD_W = PRICE_BITS + REL_W;

    logic [PRICE_BITS-1:0] diff;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     shifted;
    logic [PRICE_BITS-1:0] rel_stop;
    logic [PROD_W-1:0]     abs_ext;

    // Distance moved from the entry price, scaled by the fractional factor.
    assign diff    = (i_price >= i_entry) ? (i_price - i_entry) : (i_entry - i_price);
    assign product = PROD_W'(diff) * PROD_W'(i_cfg.stop_relative);
    assign shifted = product >> REL_FRAC_BITS;

    assign rel_stop = (|shifted[PROD_W-1:PRICE_BITS]) ? {PRICE_BITS{1'b1}}
                                                       : shifted[PRICE_BITS-1:0];

    assign abs_ext    = PROD_W'(i_cfg.stop_absolute);
    assign o_abs_stop = (|abs_ext[PROD_W-1:PRICE_BITS]) ? {PRICE_BITS{1'b1}}
                                                         : abs_ext[PRICE_BITS-1:0];

    assign o_expanded_stop = (rel_stop > o_abs_stop) ? rel_stop : o_abs_stop;

endmodule

`default_nettype wire

// File: hdl/expanding_trailing_stop.sv
// Top level of the expanding trailing stop for one open position.
//
// Usage: configuration words on i_cfg set the direction (long or short), the
// minimum stop distance, the relative stop factor and the hold limit. They are
// always accepted and should only be written while no word is in flight.
// Each word on i_in is either an open command, which records the entry prices
// and resets the stop to its minimum, or a price tick with ask and bid. Every
// input word gives exactly one result word on o_out: the close decision, a
// flag marking a close caused by the hold limit, and the stop distance after
// that word.
// Words pass through the input register, then the evaluation and state
// update in a single pass into the result register. One word is accepted per
// cycle while the receiver takes results; the multiply for the relative stop sits in that single pass.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; only then does i_in.ready drop.
// Reset empties both registers, clears all prices, the stop and the tick
// count, and restores the configuration defaults (long, zero stops, hold
// limit of 10000 ticks).
`default_nettype none

module expanding_trailing_stop
    import ets_pkg::*;
#(
    parameter int PRICE_BITS    = 32,
    parameter int REL_FRAC_BITS = 12
) (
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    ets_in_if.sink    i_in,
    ets_cfg_if.sink   i_cfg,
    ets_out_if.source o_out
);

    localparam int PEXT_W = PRICE_BITS + PRICE_PORT_W;

    // Configuration registers.
    t_ets_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= DIR_LONG;
            r_cfg.stop_absolute <= '0;
            r_cfg.stop_relative <= '0;
            r_cfg.hold_limit    <= HOLD_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DIRECTION:     r_cfg.direction     <= i_cfg.data[0];
                REG_STOP_ABSOLUTE: r_cfg.stop_absolute <= i_cfg.data[PRICE_PORT_W-1:0];
                REG_STOP_RELATIVE: r_cfg.stop_relative <= i_cfg.data[REL_W-1:0];
                REG_HOLD_LIMIT:    r_cfg.hold_limit    <= i_cfg.data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register. Prices are reduced to the internal price width here.
    logic                  r_in_valid;
    logic                  r_in_cmd;
    logic [PRICE_BITS-1:0] r_in_ask;
    logic [PRICE_BITS-1:0] r_in_bid;
    logic [PEXT_W-1:0]     ask_ext;
    logic [PEXT_W-1:0]     bid_ext;
    logic                  in_accept;
    logic                  advance;

    logic                  r_out_valid;

    // The evaluation stage moves whenever the result register is free or
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign ask_ext = PEXT_W'(i_in.ask);
    assign bid_ext = PEXT_W'(i_in.bid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd <= i_in.command;
            r_in_ask <= ask_ext[PRICE_BITS-1:0];
            r_in_bid <= bid_ext[PRICE_BITS-1:0];
        end
    end

    // Position state.
    logic [PRICE_BITS-1:0] r_entry_ask, n_entry_ask;
    logic [PRICE_BITS-1:0] r_entry_bid, n_entry_bid;
    logic [PRICE_BITS-1:0] r_ref_ask,   n_ref_ask;
    logic [PRICE_BITS-1:0] r_ref_bid,   n_ref_bid;
    logic [PRICE_BITS-1:0] r_stop,      n_stop;
    logic [TICK_W-1:0]     r_ticks,     n_ticks;

    // Stop arithmetic works on the favorable side of the position: ask for a
    // long position, bid for a short one.
    logic                  is_long;
    logic [PRICE_BITS-1:0] calc_price;
    logic [PRICE_BITS-1:0] calc_entry;
    logic [PRICE_BITS-1:0] abs_stop;
    logic [PRICE_BITS-1:0] expanded_stop;

    assign is_long    = (r_cfg.direction == DIR_LONG);
    assign calc_price = is_long ? r_in_ask : r_in_bid;
    assign calc_entry = is_long ? r_entry_ask : r_entry_bid;

    ets_stop_calc #(
        .PRICE_BITS    (PRICE_BITS),
        .REL_FRAC_BITS (REL_FRAC_BITS)
    ) u_stop_calc (
        .i_cfg           (r_cfg),
        .i_price         (calc_price),
        .i_entry         (calc_entry),
        .o_abs_stop      (abs_stop),
        .o_expanded_stop (expanded_stop)
    );

    // Tick bookkeeping and the close comparisons. The sums carry one extra
    // bit so that a stop reaching past the top of the price range never
    // wraps into a false close.
    logic [TICK_W-1:0]   ticks_inc;
    logic                timeout;
    logic                new_extreme;
    logic [PRICE_BITS:0] long_floor_sum;
    logic [PRICE_BITS:0] short_ceil_sum;
    logic                long_hit;
    logic                short_hit;

    assign ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign timeout   = ticks_inc > {1'b0, r_cfg.hold_limit};

    assign new_extreme = is_long ? (r_in_ask > r_ref_ask) : (r_in_bid < r_ref_bid);

    assign long_floor_sum = {1'b0, r_in_bid} + {1'b0, r_stop};
    assign short_ceil_sum = {1'b0, r_ref_ask} + {1'b0, r_stop};
    assign long_hit       = long_floor_sum < {1'b0, r_ref_bid};
    assign short_hit      = {1'b0, r_in_ask} > short_ceil_sum;

    logic res_close;
    logic res_timed_out;

    always_comb begin
        n_entry_ask   = r_entry_ask;
        n_entry_bid   = r_entry_bid;
        n_ref_ask     = r_ref_ask;
        n_ref_bid     = r_ref_bid;
        n_stop        = r_stop;
        n_ticks       = r_ticks;
        res_close     = 1'b0;
        res_timed_out = 1'b0;
        if (r_in_cmd == CMD_OPEN) begin
            n_entry_ask = r_in_ask;
            n_entry_bid = r_in_bid;
            n_ref_ask   = r_in_ask;
            n_ref_bid   = r_in_bid;
            n_stop      = abs_stop;
            n_ticks     = '0;
        end else begin
            n_ticks = ticks_inc;
            // The hold limit wins over everything and leaves the reference
            // and stop alone.
            priority if (timeout) begin
                res_close     = 1'b1;
                res_timed_out = 1'b1;
            end else if (new_extreme) begin
                n_ref_ask = r_in_ask;
                n_ref_bid = r_in_bid;
                n_stop    = expanded_stop;
            end else begin
                res_close = is_long ? long_hit : short_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_ask <= '0;
            r_entry_bid <= '0;
            r_ref_ask   <= '0;
            r_ref_bid   <= '0;
            r_stop      <= '0;
            r_ticks     <= '0;
        end else if (advance) begin
            r_entry_ask <= n_entry_ask;
            r_entry_bid <= n_entry_bid;
            r_ref_ask   <= n_ref_ask;
            r_ref_bid   <= n_ref_bid;
            r_stop      <= n_stop;
            r_ticks     <= n_ticks;
        end
    end

    // Result register. The reported stop saturates to the port width.
    logic [PEXT_W-1:0]       stop_ext;
    logic [PRICE_PORT_W-1:0] stop_port;
    logic                    r_out_close;
    logic                    r_out_timed_out;
    logic [PRICE_PORT_W-1:0] r_out_stop;

    assign stop_ext  = PEXT_W'(n_stop);
    assign stop_port = (|stop_ext[PEXT_W-1:PRICE_PORT_W]) ? {PRICE_PORT_W{1'b1}}
                                                          : stop_ext[PRICE_PORT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_close     <= res_close;
            r_out_timed_out <= res_timed_out;
            r_out_stop      <= stop_port;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.close         = r_out_close;
    assign o_out.timed_out     = r_out_timed_out;
    assign o_out.stop_distance = r_out_stop;

endmodule

`default_nettype wire

// File: hdl/ets_checker.sv
// Port-level checks of the expanding trailing stop and their binding.
`default_nettype none

module ets_checker
    import ets_pkg::*;
(
    input var logic i_clk,
    input var logic i_rst_n,
    input var logic i_in_valid,
    input var logic i_in_ready,
    input var logic i_in_command,
    input var logic i_out_valid,
    input var logic i_out_ready,
    input var logic i_out_close,
    input var logic i_out_timed_out
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result word stays on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A free result side always lets a new input word in.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled although the result side is taking words");

    // An accepted word passes the input register into the result register when the receiver is ready.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_out_ready |=> i_out_valid)
        else $error("result word missing two cycles after an accepted word");

    // An open command never reports a close.
    a_open_no_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_command == CMD_OPEN) ##1 i_out_ready
            |=> !i_out_close && !i_out_timed_out)
        else $error("open command reported a close");

endmodule

bind expanding_trailing_stop ets_checker u_ets_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_command    (i_in.command),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_close     (o_out.close),
    .i_out_timed_out (o_out.timed_out)
);

`default_nettype wire
